### src/uvs_pkg.sv
package uvs_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned ZW = 34;
  localparam int unsigned XW = 34;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic signed [XW-1:0] GainQ30 = 34'sd652032874;
  localparam int unsigned DefMaxRings = 255;
  localparam int unsigned DefMaxSegments = 255;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_RINGS   = 2'd1,
    REG_SEGS    = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_e;

  // arctangent of 2^-i in signed Q4.30
  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      default: r = $signed({{(ZW-1){1'b0}}, 1'b1}) <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // one CORDIC pair travelling along the chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // item context travelling alongside the rotation
  typedef struct packed {
    logic [1:0]  quad_r;
    logic [1:0]  quad_s;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [7:0]  nr;
    logic [7:0]  ns;
    logic [15:0] radius;
  } ctx_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] tri_index;
    logic        last;
  } res_t;

endpackage

### src/uvs_if.sv
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_pos;
  logic [7:0] seg_pos;
  modport source (output valid, ring_pos, seg_pos, input ready);
  modport sink (input valid, ring_pos, seg_pos, output ready);
endinterface

interface uvs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [16:0] pos_x;
  logic [16:0] pos_y;
  logic [16:0] pos_z;
  logic [15:0] norm_x;
  logic [15:0] norm_y;
  logic [15:0] norm_z;
  logic [16:0] tex_u;
  logic [16:0] tex_v;
  logic [15:0] tri_index;
  logic        last;
  modport source (output valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, tri_index, last, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                tex_u, tex_v, tri_index, last, output ready);
endinterface

interface uvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/uvs_div.sv
// restoring divider, one quotient bit per cell, num / den
module uvs_div #(
  parameter int unsigned NW = 41,
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_w [NW+1];
  logic [NW-1:0] num_w [NW+1];
  logic [DW-1:0] den_w [NW+1];

  assign rem_w[0] = '0;
  assign num_w[0] = num_i;
  assign den_w[0] = den_i;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_d, rem_q, den_q;
    logic [NW-1:0] num_d, num_q;
    // shift in next numerator bit, subtract when it fits
    always_comb begin
      trial = {rem_w[g], num_w[g][NW-1]};
      take = trial >= {1'b0, den_w[g]};
      rem_d = take ? DW'(trial - {1'b0, den_w[g]}) : trial[DW-1:0];
      num_d = {num_w[g][NW-2:0], take};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
      end else if (en_i) begin
        rem_q <= rem_d;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q <= num_d;
        den_q <= den_w[g];
      end
    end
    assign rem_w[g+1] = rem_q;
    assign num_w[g+1] = num_q;
    assign den_w[g+1] = den_q;
  end

  assign quo_o = num_w[NW];

endmodule

### src/uvs_cordic_cell.sv
// one CORDIC micro-rotation stage, registered
module uvs_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  uvs_pkg::rot_t a_i,
  output uvs_pkg::rot_t a_o
);

  localparam logic [4:0] StepIdx = 5'(STEP);
  uvs_pkg::rot_t a_d;
  logic signed [uvs_pkg::XW-1:0] dx, dy;

  always_comb begin
    dx = a_i.y >>> STEP;
    dy = a_i.x >>> STEP;
    if (!a_i.z[uvs_pkg::ZW-1]) begin
      a_d.x = a_i.x - dx;
      a_d.y = a_i.y + dy;
      a_d.z = a_i.z - uvs_pkg::atan_step(StepIdx);
    end else begin
      a_d.x = a_i.x + dx;
      a_d.y = a_i.y - dy;
      a_d.z = a_i.z + uvs_pkg::atan_step(StepIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= a_d;
    end
  end

endmodule

### src/uv_sphere_vertex_generator.sv
// Path from the accepting edge to the vertex result: 41 divider cells, 24 CORDIC
// cells, product, delay and vertex stages, output register.
// Each item gives seven results on the single result channel, so a new item
// loads only once the last one is through; an item on the last ring gives one.
// The chain advances as a whole and stalls when its tail is valid and the output is busy.
// Reset: rst_ni asynchronous, active low; radius 1.0, 16 rings, 16 segments.
module uv_sphere_vertex_generator #(
  parameter int unsigned MAX_RINGS = uvs_pkg::DefMaxRings,
  parameter int unsigned MAX_SEGMENTS = uvs_pkg::DefMaxSegments
) (
  input  logic clk_i,
  input  logic rst_ni,
  uvs_in_if.sink    in_i,
  uvs_cfg_if.sink   cfg_i,
  uvs_out_if.source out_o
);

  localparam int unsigned NW = 41;
  localparam int unsigned DLAT = NW;
  localparam int unsigned CLAT = uvs_pkg::CordicSteps;
  localparam int unsigned PLAT = DLAT + CLAT + 3;
  localparam logic [7:0] MaxR = 8'(MAX_RINGS);
  localparam logic [7:0] MaxS = 8'(MAX_SEGMENTS);

  // configuration registers
  logic [15:0] radius_q;
  logic [7:0]  nr_q, ns_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      nr_q <= 8'd16;
      ns_q <= 8'd16;
    end else if (cfg_i.valid) begin
      unique case (uvs_pkg::reg_idx_e'(cfg_i.index))
        uvs_pkg::REG_RADIUS: radius_q <= cfg_i.data;
        uvs_pkg::REG_RINGS:  nr_q <= (cfg_i.data[7:0] > MaxR) ? MaxR : cfg_i.data[7:0];
        uvs_pkg::REG_SEGS:   ns_q <= (cfg_i.data[7:0] > MaxS) ? MaxS : cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // the whole chain advances when the tail can be taken
  logic en, tail_v, buf_free;
  logic [PLAT-1:0] v_q;
  assign tail_v = v_q[PLAT-1];
  assign en = !tail_v || buf_free;
  assign in_i.ready = en;

  logic acc, good;
  assign acc = in_i.valid && in_i.ready;
  assign good = (nr_q != 8'd0) && (ns_q != 8'd0) && (in_i.ring_pos <= nr_q)
                && (in_i.seg_pos <= ns_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PLAT-2:0], acc && good};
    end
  end

  // phase and texture dividers
  logic [NW-1:0] ph_r_num, ph_s_num, tu_num, tv_num;
  logic [NW-1:0] ph_r_quo, ph_s_quo, tu_quo, tv_quo;
  assign ph_r_num = {1'b0, in_i.ring_pos, 32'd0} + NW'(nr_q);
  assign ph_s_num = {1'b0, in_i.seg_pos, 32'd0} + NW'(ns_q >> 1);
  assign tu_num = NW'({in_i.seg_pos, 16'd0}) + NW'(ns_q >> 1);
  assign tv_num = NW'({in_i.ring_pos, 16'd0}) + NW'(nr_q >> 1);

  uvs_div #(.NW(NW), .DW(9)) u_div_pr (.clk_i, .rst_ni, .en_i(en), .num_i(ph_r_num),
    .den_i({nr_q, 1'b0}), .quo_o(ph_r_quo));
  uvs_div #(.NW(NW), .DW(9)) u_div_ps (.clk_i, .rst_ni, .en_i(en), .num_i(ph_s_num),
    .den_i({1'b0, ns_q}), .quo_o(ph_s_quo));
  uvs_div #(.NW(NW), .DW(9)) u_div_tu (.clk_i, .rst_ni, .en_i(en), .num_i(tu_num),
    .den_i({1'b0, ns_q}), .quo_o(tu_quo));
  uvs_div #(.NW(NW), .DW(9)) u_div_tv (.clk_i, .rst_ni, .en_i(en), .num_i(tv_num),
    .den_i({1'b0, nr_q}), .quo_o(tv_quo));

  // context shift line beside the cells
  uvs_pkg::ctx_t ctx_q [PLAT];
  logic [16:0] tu_q [DLAT:PLAT-1], tv_q [DLAT:PLAT-1];
  uvs_pkg::ctx_t ctx_in, ctx_join;
  always_comb begin
    ctx_in = '0;
    ctx_in.ring = in_i.ring_pos;
    ctx_in.seg = in_i.seg_pos;
    ctx_in.nr = nr_q;
    ctx_in.ns = ns_q;
    ctx_in.radius = radius_q;
  end
  // quadrants of the dividers join at their stage
  always_comb begin
    ctx_join = ctx_q[DLAT-1];
    ctx_join.quad_r = ph_r_quo[31:30];
    ctx_join.quad_s = ph_s_quo[31:30];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx_in;
      for (int k = 1; k < PLAT; k++) begin
        if (k == DLAT) begin
          ctx_q[k] <= ctx_join;
        end else begin
          ctx_q[k] <= ctx_q[k-1];
        end
      end
      tu_q[DLAT] <= tu_quo[16:0];
      tv_q[DLAT] <= tv_quo[16:0];
      for (int k = DLAT + 1; k < PLAT; k++) begin
        tu_q[k] <= tu_q[k-1];
        tv_q[k] <= tv_q[k-1];
      end
    end
  end

  // phase to radians, start the rotations
  uvs_pkg::rot_t rr [CLAT+1], rs [CLAT+1];
  logic [61:0] zr_full, zs_full;
  logic signed [uvs_pkg::ZW-1:0] zr0, zs0;
  assign zr_full = 62'(ph_r_quo[29:0]) * 62'(uvs_pkg::PiQ30);
  assign zs_full = 62'(ph_s_quo[29:0]) * 62'(uvs_pkg::PiQ30);
  assign zr0 = $signed({3'b000, zr_full[61:31]});
  assign zs0 = $signed({3'b000, zs_full[61:31]});
  assign rr[0] = {uvs_pkg::GainQ30, {uvs_pkg::XW{1'b0}}, zr0};
  assign rs[0] = {uvs_pkg::GainQ30, {uvs_pkg::XW{1'b0}}, zs0};

  for (genvar g = 0; g < CLAT; g++) begin : g_cordic
    uvs_cordic_cell #(.STEP(g)) u_cr (.clk_i, .en_i(en), .a_i(rr[g]), .a_o(rr[g+1]));
    uvs_cordic_cell #(.STEP(g)) u_cs (.clk_i, .en_i(en), .a_i(rs[g]), .a_o(rs[g+1]));
  end

  // quadrant fix-up, then products
  localparam int unsigned QS = DLAT + CLAT;
  logic signed [uvs_pkg::XW-1:0] sr, cr, ss, cs;
  uvs_pkg::ctx_t cq;
  assign cq = ctx_q[QS-1];
  always_comb begin
    case (cq.quad_r)
      2'd0: begin cr = rr[CLAT].x;  sr = rr[CLAT].y;  end
      2'd1: begin cr = -rr[CLAT].y; sr = rr[CLAT].x;  end
      2'd2: begin cr = -rr[CLAT].x; sr = -rr[CLAT].y; end
      default: begin cr = rr[CLAT].y; sr = -rr[CLAT].x; end
    endcase
    case (cq.quad_s)
      2'd0: begin cs = rs[CLAT].x;  ss = rs[CLAT].y;  end
      2'd1: begin cs = -rs[CLAT].y; ss = rs[CLAT].x;  end
      2'd2: begin cs = -rs[CLAT].x; ss = -rs[CLAT].y; end
      default: begin cs = rs[CLAT].y; ss = -rs[CLAT].x; end
    endcase
  end

  logic signed [uvs_pkg::XW-1:0] ux_q, uy_q, uz_q, ux2_q, uy2_q, uz2_q;
  logic signed [67:0] pxs, pzs;
  assign pxs = sr * ss + 68'sd536870912;
  assign pzs = sr * cs + 68'sd536870912;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= uvs_pkg::XW'(pxs >>> 30);
      uz_q <= uvs_pkg::XW'(pzs >>> 30);
      uy_q <= cr;
      ux2_q <= ux_q;
      uy2_q <= uy_q;
      uz2_q <= uz_q;
    end
  end

  // scale by radius, round and saturate
  function automatic logic [16:0] to_pos(input logic [15:0] r,
                                         input logic signed [uvs_pkg::XW-1:0] u);
    logic signed [51:0] p;
    p = ($signed({1'b0, r}) * u + 52'sd536870912) >>> 30;
    if (p > 52'sd65535) return 17'd65535;
    if (p < -52'sd65535) return 17'h10001;
    return p[16:0];
  endfunction
  function automatic logic [15:0] to_norm(input logic signed [uvs_pkg::XW-1:0] u);
    logic signed [uvs_pkg::XW-1:0] n;
    n = (u + 34'sd32768) >>> 16;
    if (n > 34'sd16384) return 16'd16384;
    if (n < -34'sd16384) return 16'hC000;
    return n[15:0];
  endfunction

  uvs_pkg::res_t vtx_d, vtx_q;
  uvs_pkg::ctx_t oc;
  logic [15:0] w_q;
  assign oc = ctx_q[PLAT-2];
  always_comb begin
    vtx_d = '0;
    vtx_d.pos_x = to_pos(oc.radius, ux2_q);
    vtx_d.pos_y = to_pos(oc.radius, uy2_q);
    vtx_d.pos_z = to_pos(oc.radius, uz2_q);
    if (oc.radius != 16'd0) begin
      vtx_d.norm_x = to_norm(ux2_q);
      vtx_d.norm_y = to_norm(uy2_q);
      vtx_d.norm_z = to_norm(uz2_q);
    end
    vtx_d.tex_u = tu_q[PLAT-2];
    vtx_d.tex_v = tv_q[PLAT-2];
    vtx_d.last = (oc.ring == oc.nr);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vtx_q <= vtx_d;
      w_q <= 16'(oc.ring) * (16'(oc.ns) + 16'd1) + 16'(oc.seg);
    end
  end

  // sequencer: vertex then six indices, or the vertex alone on the last ring
  uvs_pkg::ctx_t tc;
  assign tc = ctx_q[PLAT-1];
  logic busy_q;
  logic [2:0] k_q;
  uvs_pkg::res_t cur_q;
  logic [15:0] wk_q, ns_k_q;
  logic last_item_q;
  logic fin;
  // the final result of an item leaves, so the next can load at once
  assign fin = busy_q && out_o.ready
               && ((k_q == 3'd5) || ((k_q == 3'd7) && last_item_q));
  assign buf_free = !busy_q || fin;

  uvs_pkg::res_t idx_res;
  always_comb begin
    idx_res = '0;
    idx_res.kind = 1'b1;
    case (k_q)
      3'd0, 3'd3: idx_res.tri_index = wk_q + ns_k_q + 16'd1;
      3'd2: idx_res.tri_index = wk_q + ns_k_q;
      3'd4: idx_res.tri_index = wk_q + 16'd1;
      default: idx_res.tri_index = wk_q;
    endcase
    idx_res.last = (k_q == 3'd5);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q <= '0;
      last_item_q <= 1'b0;
    end else if (tail_v && buf_free) begin
      busy_q <= 1'b1;
      k_q <= 3'd7;
      last_item_q <= vtx_q.last;
    end else if (busy_q && out_o.ready) begin
      if (k_q == 3'd7) begin
        if (last_item_q) busy_q <= 1'b0;
        else k_q <= 3'd0;
      end else if (k_q == 3'd5) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_v && buf_free) begin
      cur_q <= vtx_q;
      wk_q <= w_q;
      ns_k_q <= {8'd0, tc.ns};
    end
  end

  uvs_pkg::res_t o;
  assign o = (k_q == 3'd7) ? cur_q : idx_res;
  assign out_o.valid = busy_q;
  assign out_o.kind = o.kind;
  assign out_o.pos_x = o.pos_x;
  assign out_o.pos_y = o.pos_y;
  assign out_o.pos_z = o.pos_z;
  assign out_o.norm_x = o.norm_x;
  assign out_o.norm_y = o.norm_y;
  assign out_o.norm_z = o.norm_z;
  assign out_o.tex_u = o.tex_u;
  assign out_o.tex_v = o.tex_v;
  assign out_o.tri_index = o.tri_index;
  assign out_o.last = o.last;

endmodule

### src/uvs_checker.sv
module uvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic        out_last,
  input logic [15:0] out_tri
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_tri))
    else $error("result changed while stalled");

  // an index result is followed by another index result until last
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_kind && !out_last |=> out_valid && out_kind)
    else $error("index run broken");

  // a vertex not marked last is followed by index results
  a_vtx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_kind && !out_last |=> out_valid && out_kind)
    else $error("missing index results");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_kind(out_o.kind), .out_last(out_o.last), .out_tri(out_o.tri_index)
);
